/* hdl/mst_pkg.sv */
package mst_pkg;

  localparam int SlotsDefault = 16;
  localparam int CfgW = 5;
  localparam logic [CfgW-1:0] SlotCountReset = 5'd16;
  localparam int OpcodeW = 3;
  localparam int ValueW = 32;
  localparam int OutSlotW = 4;
  localparam int ActionW = 2;

  typedef enum logic [OpcodeW-1:0] {
    OP_SLOT  = 3'd0,
    OP_POS_X = 3'd1,
    OP_POS_Y = 3'd2,
    OP_TRACK = 3'd3,
    OP_SYNC  = 3'd4
  } opcode_e;

  typedef enum logic [ActionW-1:0] {
    ACT_DOWN = 2'd0,
    ACT_MOVE = 2'd1,
    ACT_UP   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic ev_apply;
    logic scan_start;
    logic scan_next;
    logic scan_load;
  } cmd_t;

  typedef struct packed {
    logic in_sync;
    logic pend_any;
    logic hit;
    logic last;
    logic out_free;
  } status_t;

endpackage

/* hdl/mst_if.sv */
interface mst_evt_if;
  logic                              valid;
  logic                              ready;
  logic [mst_pkg::OpcodeW-1:0]       opcode;
  logic signed [mst_pkg::ValueW-1:0] event_value;

  modport source (output valid, output opcode, output event_value, input ready);
  modport sink (input valid, input opcode, input event_value, output ready);
endinterface

interface mst_rpt_if;
  logic                              valid;
  logic                              ready;
  logic [mst_pkg::OutSlotW-1:0]      slot;
  logic signed [mst_pkg::ValueW-1:0] pos_x;
  logic signed [mst_pkg::ValueW-1:0] pos_y;
  logic [mst_pkg::ActionW-1:0]       action;
  logic                              last;

  modport source (output valid, output slot, output pos_x, output pos_y, output action,
                  output last, input ready);
  modport sink (input valid, input slot, input pos_x, input pos_y, input action,
                input last, output ready);
endinterface

/* hdl/mst_ram.sv */
module mst_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/mst_ctrl.sv */
module mst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mst_pkg::status_t  status_i,
  output mst_pkg::cmd_t     cmd_o
);

  mst_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mst_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    in_ready_o = 1'b0;
    cmd_o = '0;
    case (state_q)
      mst_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (status_i.in_sync) begin
            cmd_o.scan_start = 1'b1;
            state_d = mst_pkg::ST_SCAN;
          end else begin
            cmd_o.ev_apply = 1'b1;
          end
        end
      end
      mst_pkg::ST_SCAN: begin
        if (!status_i.pend_any) begin
          state_d = mst_pkg::ST_IDLE;
        end else if (status_i.hit) begin
          state_d = mst_pkg::ST_LOAD;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      mst_pkg::ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.scan_load = 1'b1;
          state_d = status_i.last ? mst_pkg::ST_IDLE : mst_pkg::ST_SCAN;
        end
      end
      default: begin
        state_d = mst_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/mst_dp.sv */
module mst_dp #(
  parameter int Slots = mst_pkg::SlotsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mst_pkg::CfgW-1:0]          cfg_wdata_i,
  input  logic [mst_pkg::OpcodeW-1:0]       opcode_i,
  input  logic signed [mst_pkg::ValueW-1:0] event_value_i,
  input  mst_pkg::cmd_t                     cmd_i,
  output mst_pkg::status_t                  status_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mst_pkg::OutSlotW-1:0]      out_slot_o,
  output logic signed [mst_pkg::ValueW-1:0] out_pos_x_o,
  output logic signed [mst_pkg::ValueW-1:0] out_pos_y_o,
  output logic [mst_pkg::ActionW-1:0]       out_action_o,
  output logic                              out_last_o
);

  localparam int SlotW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int VW = mst_pkg::ValueW;
  localparam int AW = mst_pkg::ActionW;

  logic [mst_pkg::CfgW-1:0] slot_count_q;
  logic [SlotW-1:0]         cur_slot_q, cur_slot_d;
  logic                     cur_valid_q, cur_valid_d;
  logic [Slots-1:0]         present_q, present_d;
  logic [Slots-1:0]         dirty_q, dirty_d;
  logic [Slots-1:0][AW-1:0] action_q, action_d;
  logic [SlotW-1:0]         idx_q, idx_d;

  logic                     out_valid_q, out_valid_d;
  logic [mst_pkg::OutSlotW-1:0] out_slot_q;
  logic [VW-1:0]            out_x_q, out_y_q;
  logic [AW-1:0]            out_action_q;
  logic                     out_last_q;

  logic [VW-1:0]            raw;
  logic                     neg;
  logic [31:0]              eff_cnt;
  logic [31:0]              sel_slot;
  logic                     created;
  logic                     x_we, y_we;
  logic [VW-1:0]            x_wdata, y_wdata;
  logic [VW-1:0]            x_rdata, y_rdata;
  logic [Slots-1:0]         pend;
  logic [Slots-1:0]         idx_onehot;
  logic [SlotW+mst_pkg::OutSlotW-1:0] idx_ext;
  logic                     out_free;

  assign raw = event_value_i;
  assign neg = raw[VW-1];

  always_comb begin
    if (slot_count_q == '0) begin
      eff_cnt = 32'd1;
    end else if (32'(slot_count_q) > 32'(Slots)) begin
      eff_cnt = 32'(Slots);
    end else begin
      eff_cnt = 32'(slot_count_q);
    end
    sel_slot = (raw >= eff_cnt) ? eff_cnt - 32'd1 : raw;
  end

  assign pend       = present_q & dirty_q;
  assign idx_onehot = Slots'(1) << idx_q;
  assign idx_ext    = (SlotW + mst_pkg::OutSlotW)'(idx_q);
  assign created    = !present_q[cur_slot_q];
  assign out_free   = !out_valid_q || out_ready_i;

  assign status_o.in_sync  = (opcode_i == mst_pkg::OP_SYNC);
  assign status_o.pend_any = |pend;
  assign status_o.hit      = pend[idx_q];
  assign status_o.last     = ((pend & ~idx_onehot) == '0);
  assign status_o.out_free = out_free;

  always_comb begin
    cur_slot_d  = cur_slot_q;
    cur_valid_d = cur_valid_q;
    present_d   = present_q;
    dirty_d     = dirty_q;
    action_d    = action_q;
    idx_d       = idx_q;
    x_we        = 1'b0;
    y_we        = 1'b0;
    x_wdata     = '0;
    y_wdata     = '0;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.ev_apply) begin
      case (opcode_i)
        mst_pkg::OP_SLOT: begin
          if (neg) begin
            cur_valid_d = 1'b0;
          end else begin
            cur_valid_d = 1'b1;
            cur_slot_d  = sel_slot[SlotW-1:0];
          end
        end
        mst_pkg::OP_POS_X, mst_pkg::OP_POS_Y: begin
          if (cur_valid_q) begin
            present_d[cur_slot_q] = 1'b1;
            dirty_d[cur_slot_q]   = 1'b1;
            if (created || !dirty_q[cur_slot_q] ||
                !(action_q[cur_slot_q] == mst_pkg::ACT_DOWN ||
                  action_q[cur_slot_q] == mst_pkg::ACT_UP)) begin
              action_d[cur_slot_q] = mst_pkg::ACT_MOVE;
            end
            if (opcode_i == mst_pkg::OP_POS_X) begin
              x_we    = 1'b1;
              x_wdata = raw;
              y_we    = created;
            end else begin
              y_we    = 1'b1;
              y_wdata = raw;
              x_we    = created;
            end
          end
        end
        mst_pkg::OP_TRACK: begin
          if (cur_valid_q) begin
            present_d[cur_slot_q] = 1'b1;
            dirty_d[cur_slot_q]   = 1'b1;
            action_d[cur_slot_q]  = neg ? mst_pkg::ACT_UP : mst_pkg::ACT_DOWN;
            x_we = created;
            y_we = created;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.scan_start) begin
      idx_d = '0;
    end
    if (cmd_i.scan_next) begin
      idx_d = idx_q + 1'b1;
    end
    if (cmd_i.scan_load) begin
      idx_d = idx_q + 1'b1;
      dirty_d[idx_q] = 1'b0;
      if (action_q[idx_q] == mst_pkg::ACT_UP) begin
        present_d[idx_q] = 1'b0;
      end
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= mst_pkg::SlotCountReset;
      cur_slot_q   <= '0;
      cur_valid_q  <= 1'b1;
      present_q    <= '0;
      dirty_q      <= '0;
      action_q     <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        slot_count_q <= cfg_wdata_i;
      end
      cur_slot_q  <= cur_slot_d;
      cur_valid_q <= cur_valid_d;
      present_q   <= present_d;
      dirty_q     <= dirty_d;
      action_q    <= action_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_load) begin
      out_slot_q   <= idx_ext[mst_pkg::OutSlotW-1:0];
      out_x_q      <= x_rdata;
      out_y_q      <= y_rdata;
      out_action_q <= action_q[idx_q];
      out_last_q   <= status_o.last;
    end
  end

  mst_ram #(.Width(VW), .Depth(Slots), .AddrW(SlotW)) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (cur_slot_q),
    .wdata_i (x_wdata),
    .raddr_i (idx_q),
    .rdata_o (x_rdata)
  );

  mst_ram #(.Width(VW), .Depth(Slots), .AddrW(SlotW)) u_y_ram (
    .clk_i   (clk_i),
    .we_i    (y_we),
    .waddr_i (cur_slot_q),
    .wdata_i (y_wdata),
    .raddr_i (idx_q),
    .rdata_o (y_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign out_slot_o   = out_slot_q;
  assign out_pos_x_o  = out_x_q;
  assign out_pos_y_o  = out_y_q;
  assign out_action_o = out_action_q;
  assign out_last_o   = out_last_q;

endmodule

/* hdl/multitouch_slot_tracker.sv */
// A slot select, position, tracking or ignored event is accepted in the idle state and is reported nowhere.
// A sync is accepted, then the scan steps through the slots up to the last pending one and loads
// each report into the output register, waiting in the load state while that register is full.
// The output register holds a finished report, so the next event is taken while it waits.
// Reset is asynchronous and active low; it clears all present and dirty marks, selects slot 0
// and sets the slot count to 16. Coordinate memories are not cleared.
module multitouch_slot_tracker #(
  parameter int SLOTS = mst_pkg::SlotsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [mst_pkg::CfgW-1:0] cfg_wdata_i,
  mst_evt_if.sink                  evt_i,
  mst_rpt_if.source                rpt_o
);

  mst_pkg::cmd_t    cmd;
  mst_pkg::status_t status;

  mst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (evt_i.valid),
    .in_ready_o (evt_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mst_dp #(.Slots(SLOTS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .opcode_i      (evt_i.opcode),
    .event_value_i (evt_i.event_value),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (rpt_o.valid),
    .out_ready_i   (rpt_o.ready),
    .out_slot_o    (rpt_o.slot),
    .out_pos_x_o   (rpt_o.pos_x),
    .out_pos_y_o   (rpt_o.pos_y),
    .out_action_o  (rpt_o.action),
    .out_last_o    (rpt_o.last)
  );

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan_load |-> (!rpt_o.valid || rpt_o.ready))
    else $error("Report loaded while the output register was still full.");

  a_no_accept_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.scan_load || cmd.scan_next) |-> !evt_i.ready)
    else $error("Event accepted during a sync scan.");

  a_event_no_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_i.valid && evt_i.ready && evt_i.opcode != mst_pkg::OP_SYNC) |=> !cmd.scan_load)
    else $error("Report started without a sync.");

  a_load_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan_load |=> rpt_o.valid)
    else $error("Loaded report not presented.");

endmodule

/* test/mst_checker.sv */
`timescale 1ns / 100ps

module mst_checker
  import mst_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  mst_evt_if              evt,
  mst_rpt_if              rpt,
  output int unsigned     fail_count,
  output int unsigned     reports_pending
);

  localparam int Slots = SlotsDefault;

  typedef struct packed {
    logic [OutSlotW-1:0] slot;
    logic [ValueW-1:0]   pos_x;
    logic [ValueW-1:0]   pos_y;
    action_e             action;
    logic                last;
  } contact_report_t;

  contact_report_t   expected_reports[$];
  logic [CfgW-1:0]   slot_count;
  int unsigned       cur_slot;
  logic              cur_slot_valid;
  logic              present[Slots];
  logic              dirty[Slots];
  action_e           contact_action[Slots];
  logic [ValueW-1:0] contact_x[Slots];
  logic [ValueW-1:0] contact_y[Slots];
  int unsigned       mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic int unsigned usable_slots();
    int unsigned cnt;
    cnt = 32'(slot_count);
    if (cnt == 0) return 1;
    if (cnt > Slots) return Slots;
    return cnt;
  endfunction

  // Creates the current slot's contact if needed; returns its index, or -1 when no slot is selected.
  function automatic int open_contact();
    if (!cur_slot_valid) return -1;
    if (!present[cur_slot]) begin
      present[cur_slot] = 1'b1;
      dirty[cur_slot] = 1'b0;
      contact_action[cur_slot] = ACT_MOVE;
      contact_x[cur_slot] = '0;
      contact_y[cur_slot] = '0;
    end
    return cur_slot;
  endfunction

  task automatic apply_event(input logic [OpcodeW-1:0] op, input logic [ValueW-1:0] raw);
    int s;
    int unsigned limit;
    int unsigned remaining;
    contact_report_t rep;
    case (op)
      OP_SLOT: begin
        if (raw[ValueW-1]) begin
          cur_slot_valid = 1'b0;
        end else begin
          limit = usable_slots();
          cur_slot_valid = 1'b1;
          cur_slot = (raw >= limit) ? limit - 1 : raw;
        end
      end
      OP_POS_X, OP_POS_Y: begin
        s = open_contact();
        if (s >= 0) begin
          if (op == OP_POS_X) contact_x[s] = raw;
          else contact_y[s] = raw;
          if (!(dirty[s] && (contact_action[s] == ACT_DOWN || contact_action[s] == ACT_UP))) begin
            contact_action[s] = ACT_MOVE;
          end
          dirty[s] = 1'b1;
        end
      end
      OP_TRACK: begin
        s = open_contact();
        if (s >= 0) begin
          contact_action[s] = raw[ValueW-1] ? ACT_UP : ACT_DOWN;
          dirty[s] = 1'b1;
        end
      end
      OP_SYNC: begin
        remaining = 0;
        for (int i = 0; i < Slots; i++) begin
          if (present[i] && dirty[i]) remaining++;
        end
        for (int i = 0; i < Slots; i++) begin
          if (present[i] && dirty[i]) begin
            remaining--;
            rep.slot = OutSlotW'(i);
            rep.pos_x = contact_x[i];
            rep.pos_y = contact_y[i];
            rep.action = contact_action[i];
            rep.last = (remaining == 0);
            expected_reports.push_back(rep);
            dirty[i] = 1'b0;
            if (contact_action[i] == ACT_UP) present[i] = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_report();
    contact_report_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch($sformatf("report for slot %0d with none expected", rpt.slot));
      return;
    end
    want = expected_reports.pop_front();
    if (rpt.slot !== want.slot) begin
      report_mismatch($sformatf("slot %0d, expected %0d", rpt.slot, want.slot));
    end
    if (rpt.pos_x !== want.pos_x) begin
      report_mismatch($sformatf("slot %0d pos_x %0d, expected %0d", want.slot, rpt.pos_x,
                                $signed(want.pos_x)));
    end
    if (rpt.pos_y !== want.pos_y) begin
      report_mismatch($sformatf("slot %0d pos_y %0d, expected %0d", want.slot, rpt.pos_y,
                                $signed(want.pos_y)));
    end
    if (rpt.action !== want.action) begin
      report_mismatch($sformatf("slot %0d action %0d, expected %0d", want.slot, rpt.action,
                                want.action));
    end
    if (rpt.last !== want.last) begin
      report_mismatch($sformatf("slot %0d last %0b, expected %0b", want.slot, rpt.last,
                                want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_reports.delete();
      slot_count = SlotCountReset;
      cur_slot = 0;
      cur_slot_valid = 1'b1;
      for (int i = 0; i < Slots; i++) begin
        present[i] = 1'b0;
        dirty[i] = 1'b0;
        contact_action[i] = ACT_DOWN;
        contact_x[i] = '0;
        contact_y[i] = '0;
      end
      reports_pending <= 0;
    end else begin
      if (cfg_we_i) slot_count = cfg_wdata_i;
      if (evt.valid && evt.ready) apply_event(evt.opcode, evt.event_value);
      if (rpt.valid && rpt.ready) check_report();
      reports_pending <= expected_reports.size();
    end
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import mst_pkg::*;

  localparam int Slots = SlotsDefault;
  localparam logic [OpcodeW-1:0] OpIgnoredFirst = 3'd5;
  localparam logic [OpcodeW-1:0] OpIgnoredLast = 3'd7;
  localparam int MaxGap = 14;
  localparam int LongHold = 400;
  localparam int QuietCycles = 2 * Slots + 8;
  localparam int Phases = 8;
  localparam int ItemsPerPhase = 33;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;
  int unsigned     fail_count;
  int unsigned     reports_pending;
  int unsigned     events_sent = 0;
  bit              send_gaps_on = 1'b1;
  bit              take_gaps_on = 1'b1;
  bit              long_hold_request = 1'b0;

  mst_evt_if evt_bus ();
  mst_rpt_if rpt_bus ();

  multitouch_slot_tracker u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .evt_i       (evt_bus),
    .rpt_o       (rpt_bus)
  );

  mst_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .evt             (evt_bus),
    .rpt             (rpt_bus),
    .fail_count      (fail_count),
    .reports_pending (reports_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned hold;
    rpt_bus.ready <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (long_hold_request) begin
        hold = LongHold;
        long_hold_request = 1'b0;
      end else begin
        hold = take_gaps_on ? $urandom_range(0, MaxGap) : 0;
      end
      if (hold > 0) begin
        rpt_bus.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      rpt_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!rpt_bus.valid) @(posedge clk_i);
    end
  end

  task automatic send_event(input logic [OpcodeW-1:0] op, input logic [ValueW-1:0] value);
    int unsigned gap;
    gap = send_gaps_on ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      evt_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    evt_bus.valid <= 1'b1;
    evt_bus.opcode <= op;
    evt_bus.event_value <= value;
    @(posedge clk_i);
    while (!evt_bus.ready) @(posedge clk_i);
    events_sent++;
  endtask

  task automatic settle();
    evt_bus.valid <= 1'b0;
    do @(posedge clk_i); while (reports_pending != 0);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  task automatic write_slot_count(input logic [CfgW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_frame();
    int unsigned contacts;
    int unsigned pick;
    logic [ValueW-1:0] slot_value;
    contacts = $urandom_range(1, 4);
    for (int c = 0; c < contacts; c++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) slot_value = {1'b1, 31'($urandom)};
      else if (pick == 1) slot_value = $urandom;
      else slot_value = $urandom_range(0, Slots - 1);
      send_event(OP_SLOT, slot_value);
      if ($urandom_range(0, 2) == 0) send_event(OP_TRACK, $urandom);
      if ($urandom_range(0, 9) < 7) send_event(OP_POS_X, $urandom);
      if ($urandom_range(0, 9) < 7) send_event(OP_POS_Y, $urandom);
      if ($urandom_range(0, 9) == 0) begin
        send_event(OpcodeW'($urandom_range(0, OpIgnoredLast)), $urandom);
      end
    end
    if ($urandom_range(0, 9) != 0) send_event(OP_SYNC, $urandom);
  endtask

  initial begin
    logic [CfgW-1:0] slot_count_plan [6];
    int unsigned phase_goal;
    slot_count_plan = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd16, 5'd2};
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    evt_bus.valid <= 1'b0;
    evt_bus.opcode <= '0;
    evt_bus.event_value <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_event(OP_TRACK, 32'd0);
    send_event(OP_POS_X, 32'h7fff_ffff);
    send_event(OP_POS_Y, 32'h8000_0000);
    send_event(OP_SLOT, 32'd15);
    send_event(OP_POS_X, 32'h8000_0000);
    send_event(OP_SLOT, 32'd16);
    send_event(OP_POS_Y, 32'hffff_ffff);
    send_event(OP_SLOT, 32'h7fff_ffff);
    send_event(OP_SYNC, 32'd0);
    send_event(OP_SYNC, 32'hffff_ffff);
    send_event(OP_SLOT, 32'hffff_ffff);
    send_event(OP_POS_X, 32'd123);
    send_event(OP_TRACK, 32'hffff_fffb);
    send_event(OP_SLOT, 32'd0);
    send_event(OP_TRACK, 32'h8000_0000);
    send_event(OP_POS_X, 32'd0);
    send_event(OP_SLOT, 32'd3);
    send_event(OP_TRACK, 32'h7fff_ffff);
    send_event(OpIgnoredFirst, 32'd1);
    send_event(OpcodeW'(OpIgnoredFirst + 1), 32'h5555_aaaa);
    send_event(OpIgnoredLast, 32'hffff_ffff);
    send_event(OP_SYNC, 32'd0);
    send_event(OP_SLOT, 32'd0);
    send_event(OP_POS_Y, 32'd7);
    send_event(OP_SLOT, 32'd3);
    send_event(OP_POS_X, 32'd1);
    send_event(OP_SYNC, 32'd0);
    settle();

    for (int p = 0; p < Phases; p++) begin
      write_slot_count(p < 6 ? slot_count_plan[p] : CfgW'($urandom_range(0, 31)));
      send_gaps_on = (p % 3) != 0;
      take_gaps_on = (p % 4) != 2;
      long_hold_request = (p == 3);
      phase_goal = events_sent + ItemsPerPhase;
      while (events_sent < phase_goal) send_frame();
      settle();
    end

    if (fail_count == 0 && reports_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/mst_pkg.sv
hdl/mst_if.sv
hdl/mst_ram.sv
hdl/mst_ctrl.sv
hdl/mst_dp.sv
hdl/multitouch_slot_tracker.sv
test/mst_checker.sv
test/testbench.sv
